// ===== design/stg_pkg.sv =====
// ----------------------------------------------------------------------------
// stg_pkg
// Shared types, constants and the quarter-wave sine table of the tone
// generator and mixer.
// ----------------------------------------------------------------------------
package stg_pkg;

    localparam int PHASE_BITS_DEF   = 32;
    localparam int STEP_BITS        = 32;
    localparam int AMP_BITS         = 15;
    localparam int COUNT_BITS       = 25;
    localparam int INDEX_BITS       = 24;
    localparam int SAMPLE_BITS      = 16;
    localparam int MAG_BITS         = 15;
    localparam int MAX_TONE_SAMPLES = 16777216;
    localparam int SINE_TABLE_DEPTH = 256;
    localparam int SINE_IDX_BITS    = $clog2(SINE_TABLE_DEPTH);
    localparam int ROM_ADDR_BITS    = SINE_IDX_BITS + 1;
    localparam int ROM_BITS         = MAG_BITS * (SINE_TABLE_DEPTH + 1);
    localparam int ADDR_BITS        = 4;
    localparam int DATA_BITS        = 32;

    localparam logic [1:0] REG_PHASE_STEP     = 2'd0;
    localparam logic [1:0] REG_TONE_AMPLITUDE = 2'd1;
    localparam logic [1:0] REG_SAMPLE_COUNT   = 2'd2;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef struct packed {
        logic [STEP_BITS-1:0]  phase_step;
        logic [AMP_BITS-1:0]   tone_amplitude;
        logic [COUNT_BITS-1:0] sample_count;
    } stg_cfg_t;

    typedef struct packed {
        logic accept;
        logic amp_en;
        logic mix_en;
        logic out_load;
    } stg_cmd_t;

    function automatic logic [63:0] udiv_u64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den})
            begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic logic [ROM_BITS-1:0] sine_rom_init();
        logic [ROM_BITS-1:0] rom;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] den;
        rom = '0;
        for (int k = 0; k <= SINE_TABLE_DEPTH; k++)
        begin
            x = (HALF_PI_Q30 * 64'(k) + 64'(SINE_TABLE_DEPTH / 2)) / 64'(SINE_TABLE_DEPTH);
            x2 = (x * x) >> 30;
            term = x;
            sum = x;
            for (int n = 1; n <= 8; n++)
            begin
                den = 64'((2 * n) * (2 * n + 1));
                term = udiv_u64((term * x2) >> 30, den);
                if ((n % 2) == 1)
                begin
                    sum = (sum >= term) ? sum - term : 64'd0;
                end
                else
                begin
                    sum = sum + term;
                end
            end
            if (sum > (64'd1 << 30))
            begin
                sum = 64'd1 << 30;
            end
            rom[k*MAG_BITS +: MAG_BITS] = MAG_BITS'((sum * 64'd32767 + (64'd1 << 29)) >> 30);
        end
        return rom;
    endfunction

    localparam logic [ROM_BITS-1:0] SINE_ROM = sine_rom_init();

endpackage

// ===== design/stg_regs.sv =====
// ----------------------------------------------------------------------------
// stg_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module stg_regs
    import stg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0] prdata,
    output logic                 pready,
    output stg_cfg_t             cfg
);

    stg_cfg_t cfg_reg;
    stg_cfg_t cfg_next;
    logic     wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_PHASE_STEP:     cfg_next.phase_step     = pwdata[STEP_BITS-1:0];
                REG_TONE_AMPLITUDE: cfg_next.tone_amplitude = pwdata[AMP_BITS-1:0];
                REG_SAMPLE_COUNT:   cfg_next.sample_count   = pwdata[COUNT_BITS-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_PHASE_STEP:     prdata = cfg_reg.phase_step;
            REG_TONE_AMPLITUDE: prdata = {{(DATA_BITS-AMP_BITS){1'b0}}, cfg_reg.tone_amplitude};
            REG_SAMPLE_COUNT:   prdata = {{(DATA_BITS-COUNT_BITS){1'b0}}, cfg_reg.sample_count};
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.phase_step     <= '0;
            cfg_reg.tone_amplitude <= '0;
            cfg_reg.sample_count   <= COUNT_BITS'(1);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== design/stg_ctrl.sv =====
// ----------------------------------------------------------------------------
// stg_ctrl
// Sequencer for one word: table read, amplitude scaling, mixing, output load.
// ----------------------------------------------------------------------------
module stg_ctrl
    import stg_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    output stg_cmd_t cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_AMP  = 2'd1;
    localparam logic [1:0] ST_MIX  = 2'd2;
    localparam logic [1:0] ST_LOAD = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd.accept   = 1'b0;
        cmd.amp_en   = 1'b0;
        cmd.mix_en   = 1'b0;
        cmd.out_load = 1'b0;
        state_next   = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_AMP;
                end
            end
            ST_AMP:
            begin
                cmd.amp_en = 1'b1;
                state_next = ST_MIX;
            end
            ST_MIX:
            begin
                cmd.mix_en = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_AMP))
        else $error("Accepted word did not start the sequence.");

    a_mix_then_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MIX) |=> (state_reg == ST_LOAD))
        else $error("Mix step was not followed by the load step.");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid_reg)
        else $error("Loaded word is not presented.");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !cmd.out_load)
        else $error("Output register overwritten before it was taken.");
`endif

endmodule

// ===== design/stg_dpath.sv =====
// ----------------------------------------------------------------------------
// stg_dpath
// Phase accumulator, sample counter, sine table, multipliers and the
// output register.
// ----------------------------------------------------------------------------
module stg_dpath
    import stg_pkg::*;
#(
    parameter int PHASE_BITS = PHASE_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  stg_cfg_t                      cfg,
    input  stg_cmd_t                      cmd,
    input  logic signed [SAMPLE_BITS-1:0] noise_sample,
    output logic signed [SAMPLE_BITS-1:0] tone_sample,
    output logic signed [SAMPLE_BITS-1:0] mixed_sample,
    output logic [INDEX_BITS-1:0]         sample_index,
    output logic                          last_sample
);

    localparam int QSH = PHASE_BITS - 2;

    logic [PHASE_BITS-1:0]         phase_acc_reg;
    logic [PHASE_BITS-1:0]         step_scaled;
    logic [INDEX_BITS-1:0]         counter_reg;
    logic [COUNT_BITS-1:0]         count_sat;
    logic                          last;
    logic [1:0]                    quad;
    logic [SINE_IDX_BITS-1:0]      idx;
    logic [ROM_ADDR_BITS-1:0]      rom_addr;
    logic [MAG_BITS-1:0]           mag;

    logic signed [SAMPLE_BITS-1:0] noise_reg;
    logic [1:0]                    quad_reg;
    logic [MAG_BITS-1:0]           mag_reg;
    logic [INDEX_BITS-1:0]         index_reg;
    logic                          last_reg;
    logic [2*MAG_BITS-1:0]         amp_prod;
    logic [MAG_BITS-1:0]           tmag;
    logic signed [SAMPLE_BITS-1:0] tone_next;
    logic signed [SAMPLE_BITS-1:0] tone_reg;
    logic signed [2*SAMPLE_BITS-1:0] mix_prod;
    logic signed [2*SAMPLE_BITS-1:0] mix_round;
    logic signed [SAMPLE_BITS-1:0] mixed_reg;

    logic signed [SAMPLE_BITS-1:0] tone_out_reg;
    logic signed [SAMPLE_BITS-1:0] mixed_out_reg;
    logic [INDEX_BITS-1:0]         index_out_reg;
    logic                          last_out_reg;

    generate
        if (PHASE_BITS >= STEP_BITS)
        begin : g_step_up
            assign step_scaled = PHASE_BITS'(cfg.phase_step) << (PHASE_BITS - STEP_BITS);
        end
        else
        begin : g_step_down
            assign step_scaled = PHASE_BITS'(cfg.phase_step >> (STEP_BITS - PHASE_BITS));
        end
    endgenerate

    always_comb
    begin
        if (cfg.sample_count == '0)
        begin
            count_sat = COUNT_BITS'(1);
        end
        else if (cfg.sample_count > COUNT_BITS'(MAX_TONE_SAMPLES))
        begin
            count_sat = COUNT_BITS'(MAX_TONE_SAMPLES);
        end
        else
        begin
            count_sat = cfg.sample_count;
        end
    end

    assign last = (({1'b0, counter_reg} + COUNT_BITS'(1)) >= count_sat);

    assign quad     = phase_acc_reg[PHASE_BITS-1 -: 2];
    assign idx      = phase_acc_reg[QSH-1 -: SINE_IDX_BITS];
    assign rom_addr = quad[0] ? (ROM_ADDR_BITS'(SINE_TABLE_DEPTH) - {1'b0, idx})
                              : {1'b0, idx};
    assign mag      = SINE_ROM[rom_addr*MAG_BITS +: MAG_BITS];

    assign amp_prod  = (2*MAG_BITS)'(cfg.tone_amplitude) * (2*MAG_BITS)'(mag_reg);
    assign tmag      = MAG_BITS'((amp_prod + (2*MAG_BITS)'(16384)) >> 15);
    assign tone_next = quad_reg[1] ? -$signed({1'b0, tmag}) : $signed({1'b0, tmag});

    assign mix_prod  = (2*SAMPLE_BITS)'(noise_reg) * (2*SAMPLE_BITS)'(tone_reg);
    assign mix_round = (mix_prod + 32'sd16384) >>> 15;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_acc_reg <= '0;
            counter_reg   <= '0;
        end
        else if (cmd.accept)
        begin
            if (last)
            begin
                phase_acc_reg <= '0;
                counter_reg   <= '0;
            end
            else
            begin
                phase_acc_reg <= phase_acc_reg + step_scaled;
                counter_reg   <= counter_reg + INDEX_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            noise_reg <= noise_sample;
            quad_reg  <= quad;
            mag_reg   <= mag;
            index_reg <= counter_reg;
            last_reg  <= last;
        end
        if (cmd.amp_en)
        begin
            tone_reg <= tone_next;
        end
        if (cmd.mix_en)
        begin
            mixed_reg <= mix_round[SAMPLE_BITS-1:0];
        end
        if (cmd.out_load)
        begin
            tone_out_reg  <= tone_reg;
            mixed_out_reg <= mixed_reg;
            index_out_reg <= index_reg;
            last_out_reg  <= last_reg;
        end
    end

    assign tone_sample  = tone_out_reg;
    assign mixed_sample = mixed_out_reg;
    assign sample_index = index_out_reg;
    assign last_sample  = last_out_reg;

endmodule

// ===== design/sine_tone_generator_mixer.sv =====
// ----------------------------------------------------------------------------
// sine_tone_generator_mixer
// Direct digital synthesis tone generator with a noise mixer.
// ----------------------------------------------------------------------------
// Each input word carries one Q1.15 noise sample and yields one output word
// with the tone sample (amplitude times the sine of the current phase), the
// tone times the noise, the sample's position in the tone and a flag on the
// last sample of a run. A word is accepted only while the sequencer is idle.
// The sine table is read at the edge that accepts the word; the amplitude
// multiply, the noise multiply and the output load then follow as steps of
// their own, in that order, and a new word is taken only once the output
// load of the last one is done. While an earlier word still waits in the
// output register, the load step waits with it and the input stays blocked.
// Configuration registers are at byte addresses 0 (phase_step), 4
// (tone_amplitude) and 8 (sample_count) and should be written only while
// the block is idle.
module sine_tone_generator_mixer
    import stg_pkg::*;
#(
    parameter int PHASE_BITS = PHASE_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ADDR_BITS-1:0]          paddr,
    input  logic [DATA_BITS-1:0]          pwdata,
    output logic [DATA_BITS-1:0]          prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] noise_sample,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] tone_sample,
    output logic signed [SAMPLE_BITS-1:0] mixed_sample,
    output logic [INDEX_BITS-1:0]         sample_index,
    output logic                          last_sample
);

    stg_cfg_t cfg;
    stg_cmd_t cmd;

    stg_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    stg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    stg_dpath #(
        .PHASE_BITS (PHASE_BITS)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .cmd          (cmd),
        .noise_sample (noise_sample),
        .tone_sample  (tone_sample),
        .mixed_sample (mixed_sample),
        .sample_index (sample_index),
        .last_sample  (last_sample)
    );

endmodule
